// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL. All checks are clocked on clk and
// are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Whenever pre holds, post must hold in the following cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/pgp_pkg.sv =====
package pgp_pkg;

	localparam int UNIFORM_WIDTH = 16;
	localparam int DEVIATE_WIDTH = 16;
	localparam int OUT_FRAC_BITS_DEF = 12;

	// Fraction bits of the internal log and reciprocal words.
	localparam int Q = 30;
	// Right shift applied to -2 ln S before the product with 1/x.
	localparam int T_SHIFT = 6;
	// Width of the square root result.
	localparam int GW = 32;

	// 2 ln 2 in Q30, rounded.
	localparam logic [Q:0] TWO_LN2_Q30 = 31'd1488522236;

	typedef struct packed {
		logic [UNIFORM_WIDTH-1:0] uniform_a;
		logic [UNIFORM_WIDTH-1:0] uniform_b;
	} pair_in_t;

	typedef struct packed {
		logic signed [DEVIATE_WIDTH-1:0] deviate;
		logic                            last;
	} deviate_out_t;

endpackage

// ===== design/polar_gaussian_pair_top.sv =====
// Marsaglia polar Gaussian pair generator.
// The pair channel (pair, pair_valid, pair_stall) takes two uniform samples;
// a request is taken at a clock edge with pair_valid high and pair_stall low.
// Each accepted pair is either rejected (S zero or S at least one), giving
// nothing, or gives two requests on the dev channel (dev, dev_valid,
// dev_stall): the deviate for the first sample with last low, then the one
// for the second sample with last high, in signed Q3.12 by default.
// The second deviate of a pair is presented once the first is taken with
// dev_stall low.
// Throughput: one pair per cycle enters the pipeline while pair_stall is low;
// accepted pairs leave at one deviate per cycle while dev_stall is low, so the
// dev port, with two deviates per accepted pair, sets the sustained rate. The
// pipeline length comes from the 30 log squaring steps run beside the 31 reciprocal
// division steps, and the 32 square root steps, each one register stage.
// Reset clears all valid bits; no result is pending afterward.
// While dev_stall holds a deviate, the pipeline keeps moving until its last
// stage is full, and only then raises pair_stall; nothing is lost or
// repeated.
`include "assert_macros.svh"

module polar_gaussian_pair_top import pgp_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  pair_in_t     pair,
	input  logic         pair_valid,
	output logic         pair_stall,
	output deviate_out_t dev,
	output logic         dev_valid,
	input  logic         dev_stall
);

	localparam int UW   = UNIFORM_WIDTH;
	localparam int SW   = 2 * UW - 2;
	localparam int EW   = $clog2(SW + 1);
	localparam int NS   = $clog2(SW);
	localparam int XW   = Q + 1;
	localparam int YW   = Q;
	localparam int LS   = Q + 1;
	localparam int TW   = EW + XW;
	localparam int HW   = TW - T_SHIFT;
	localparam int PRW  = HW + XW;
	localparam int PW   = 2 * GW;
	localparam int RW   = GW + 3;
	localparam int MW   = UW + GW;
	localparam int RDW  = MW + 1;
	localparam int DMAX = UW + 26 - OUT_FRAC_BITS;
	localparam int DW   = $clog2(DMAX + 1);
	localparam int DV   = DEVIATE_WIDTH;

	localparam logic [UW-1:0]  MID     = UW'(1) << (UW - 1);
	localparam logic [RDW-1:0] POS_LIM = RDW'((2 ** (DV - 1)) - 1);
	localparam logic [RDW-1:0] NEG_LIM = RDW'(2 ** (DV - 1));

	typedef struct packed {
		logic [UW-1:0] m1;
		logic [UW-1:0] m2;
		logic          n1;
		logic          n2;
		logic [EW-1:0] e;
	} side_t;

	logic adv;
	logic o_free;
	logic xv_s3;

	// ---------------- stage 1: magnitudes and signs ----------------
	logic [UW-1:0] ua, ub;
	side_t sd_s1;
	logic  v_s1;

	assign ua = pair.uniform_a;
	assign ub = pair.uniform_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= pair_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1.n1 <= !ua[UW-1];
			sd_s1.n2 <= !ub[UW-1];
			sd_s1.m1 <= ua[UW-1] ? {1'b0, ua[UW-2:0]} : MID - ua;
			sd_s1.m2 <= ub[UW-1] ? {1'b0, ub[UW-2:0]} : MID - ub;
			sd_s1.e  <= '0;
		end
	end

	// ---------------- stage 2: squares ----------------
	logic [2*UW-1:0] sq1_s2, sq2_s2;
	side_t sd_s2;
	logic  v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq1_s2 <= sd_s1.m1 * sd_s1.m1;
			sq2_s2 <= sd_s1.m2 * sd_s1.m2;
			sd_s2  <= sd_s1;
		end
	end

	// ---------------- stage 3: sum and reject test ----------------
	logic [2*UW-1:0] ssum;
	logic            s_ok;
	side_t           sd_e;
	logic [SW-1:0]   nw_s [0:NS];
	side_t           nsd_s[0:NS];
	logic            nv_s [0:NS];

	assign ssum = sq1_s2 + sq2_s2;
	assign s_ok = (ssum != '0) && (ssum[2*UW-1:SW] == '0);

	always_comb begin
		sd_e   = sd_s2;
		sd_e.e = EW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) nv_s[0] <= 1'b0;
		else if (adv) nv_s[0] <= v_s2 && s_ok;
	end

	// The exponent count starts at one, so after normalization it is e.
	always_ff @(posedge clk) begin
		if (adv) begin
			nw_s[0]  <= ssum[SW-1:0];
			nsd_s[0] <= sd_e;
		end
	end

	// ---------------- normalization: binary search for the top bit ----------------
	for (genvar k = 0; k < NS; k++) begin : g_norm
		localparam int SH = 1 << (NS - 1 - k);
		logic  zero;
		side_t sd_n;

		assign zero = (nw_s[k][SW-1 -: SH] == '0);

		always_comb begin
			sd_n = nsd_s[k];
			if (zero) sd_n.e = nsd_s[k].e + EW'(SH);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) nv_s[k+1] <= 1'b0;
			else if (adv) nv_s[k+1] <= nv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nw_s[k+1]  <= zero ? (nw_s[k] << SH) : nw_s[k];
				nsd_s[k+1] <= sd_n;
			end
		end
	end

	logic [SW+XW-1:0] xfull;
	logic [XW-1:0]    xnorm;

	assign xfull = {nw_s[NS], {XW{1'b0}}};
	assign xnorm = xfull[SW+XW-1 -: XW];

	// ---------------- log squaring steps beside reciprocal division ----------------
	logic [XW-1:0] lx_s [0:LS-1];
	logic [YW-1:0] ly_s [0:LS-1];
	logic [XW-1:0] lr_s [0:LS-1];
	logic [XW-1:0] lq_s [0:LS-1];
	logic [XW-1:0] ld_s [0:LS-1];
	side_t         lsd_s[0:LS-1];
	logic          lv_s [0:LS-1];

	for (genvar i = 0; i < LS; i++) begin : g_logdiv
		logic [XW-1:0]   xi, ri, qi, di, xo, ro, qo;
		logic [YW-1:0]   yi, yo;
		side_t           si;
		logic            vi;
		logic [XW:0]     t;
		logic            ge;

		if (i == 0) begin : g_in0
			assign xi = xnorm;
			assign di = xnorm;
			assign ri = XW'(1) << (Q - 1);
			assign qi = '0;
			assign yi = '0;
			assign si = nsd_s[NS];
			assign vi = nv_s[NS];
		end else begin : g_inn
			assign xi = lx_s[i-1];
			assign di = ld_s[i-1];
			assign ri = lr_s[i-1];
			assign qi = lq_s[i-1];
			assign yi = ly_s[i-1];
			assign si = lsd_s[i-1];
			assign vi = lv_s[i-1];
		end

		// One restoring division step of 2^60 / x.
		assign t  = {ri, 1'b0};
		assign ge = (t >= {1'b0, di});
		assign ro = ge ? XW'(t - {1'b0, di}) : t[XW-1:0];
		assign qo = {qi[XW-2:0], ge};

		// One squaring step of the base-2 log; the first stage only divides.
		if (i == 0) begin : g_nolog
			assign xo = xi;
			assign yo = yi;
		end else begin : g_log
			logic [2*XW-1:0] sq;
			logic [XW:0]     sh;

			assign sq = xi * xi;
			assign sh = sq[2*XW-1:Q];
			assign xo = sh[XW] ? sh[XW:1] : sh[XW-1:0];
			assign yo = {yi[YW-2:0], sh[XW]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) lv_s[i] <= 1'b0;
			else if (adv) lv_s[i] <= vi;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lx_s[i]  <= xo;
				ly_s[i]  <= yo;
				lr_s[i]  <= ro;
				lq_s[i]  <= qo;
				ld_s[i]  <= di;
				lsd_s[i] <= si;
			end
		end
	end

	// ---------------- -2 ln S, times 1/x ----------------
	logic [TW-1:0]    ta_s1;
	logic [YW+XW-1:0] tb_s1;
	logic [XW-1:0]    r_s1, r_s2;
	side_t            tsd_s1, tsd_s2, psd_s3;
	logic             tv_s1, tv_s2, pv_s3;
	logic [HW-1:0]    th_s2;
	logic [TW-1:0]    tdiff;
	logic [PRW-1:0]   prod;
	logic [PW-1:0]    p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s1 <= 1'b0;
			tv_s2 <= 1'b0;
			pv_s3 <= 1'b0;
		end else if (adv) begin
			tv_s1 <= lv_s[LS-1];
			tv_s2 <= tv_s1;
			pv_s3 <= tv_s2;
		end
	end

	assign tdiff = ta_s1 - TW'(tb_s1 >> Q);
	assign prod  = th_s2 * r_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s1  <= lsd_s[LS-1].e * TWO_LN2_Q30;
			tb_s1  <= ly_s[LS-1] * TWO_LN2_Q30;
			r_s1   <= lq_s[LS-1];
			tsd_s1 <= lsd_s[LS-1];
			th_s2  <= tdiff[TW-1:T_SHIFT];
			r_s2   <= r_s1;
			tsd_s2 <= tsd_s1;
			// An odd exponent leaves a factor of two inside the root.
			p_s3   <= PW'(prod) << tsd_s2.e[0];
			psd_s3 <= tsd_s2;
		end
	end

	// ---------------- square root, one result bit per stage ----------------
	logic [PW-1:0] qp_s  [0:GW-1];
	logic [RW-1:0] qrem_s[0:GW-1];
	logic [GW-1:0] qrt_s [0:GW-1];
	side_t         qsd_s [0:GW-1];
	logic          qv_s  [0:GW-1];

	for (genvar j = 0; j < GW; j++) begin : g_sqrt
		logic [PW-1:0] pin;
		logic [RW-1:0] remi, tmp, trial;
		logic [GW-1:0] rooti;
		side_t         si;
		logic          vi;
		logic          ge;

		if (j == 0) begin : g_in0
			assign pin   = p_s3;
			assign remi  = '0;
			assign rooti = '0;
			assign si    = psd_s3;
			assign vi    = pv_s3;
		end else begin : g_inn
			assign pin   = qp_s[j-1];
			assign remi  = qrem_s[j-1];
			assign rooti = qrt_s[j-1];
			assign si    = qsd_s[j-1];
			assign vi    = qv_s[j-1];
		end

		assign tmp   = {remi[RW-3:0], pin[PW-1-2*j -: 2]};
		assign trial = RW'({rooti, 2'b01});
		assign ge    = (tmp >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qv_s[j] <= 1'b0;
			else if (adv) qv_s[j] <= vi;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				qp_s[j]   <= pin;
				qrem_s[j] <= ge ? (tmp - trial) : tmp;
				qrt_s[j]  <= {rooti[GW-2:0], ge};
				qsd_s[j]  <= si;
			end
		end
	end

	// ---------------- scale, round and saturate ----------------
	logic [MW-1:0]   mg1_s1, mg2_s1;
	logic [DW-1:0]   d_s1;
	logic            n1_s1, n2_s1, n1_s2, n2_s2;
	logic            xv_s1, xv_s2;
	logic [RDW-1:0]  rd1_s2, rd2_s2, rbit;
	logic [DV-1:0]   fd1, fd2;
	logic [DV-1:0]   fd1_s3, fd2_s3;

	assign rbit = RDW'(1) << (d_s1 - DW'(1));

	always_comb begin
		if (n1_s2) fd1 = (rd1_s2 > NEG_LIM) ? NEG_LIM[DV-1:0] : DV'(0) - rd1_s2[DV-1:0];
		else       fd1 = (rd1_s2 > POS_LIM) ? POS_LIM[DV-1:0] : rd1_s2[DV-1:0];
		if (n2_s2) fd2 = (rd2_s2 > NEG_LIM) ? NEG_LIM[DV-1:0] : DV'(0) - rd2_s2[DV-1:0];
		else       fd2 = (rd2_s2 > POS_LIM) ? POS_LIM[DV-1:0] : rd2_s2[DV-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xv_s1 <= 1'b0;
			xv_s2 <= 1'b0;
			xv_s3 <= 1'b0;
		end else if (adv) begin
			xv_s1 <= qv_s[GW-1];
			xv_s2 <= xv_s1;
			xv_s3 <= xv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mg1_s1 <= qsd_s[GW-1].m1 * qrt_s[GW-1];
			mg2_s1 <= qsd_s[GW-1].m2 * qrt_s[GW-1];
			d_s1   <= DW'(DMAX) - DW'(qsd_s[GW-1].e >> 1);
			n1_s1  <= qsd_s[GW-1].n1;
			n2_s1  <= qsd_s[GW-1].n2;
			rd1_s2 <= (RDW'(mg1_s1) + rbit) >> d_s1;
			rd2_s2 <= (RDW'(mg2_s1) + rbit) >> d_s1;
			n1_s2  <= n1_s1;
			n2_s2  <= n2_s1;
			fd1_s3 <= fd1;
			fd2_s3 <= fd2;
		end
	end

	// ---------------- output: two deviates per accepted pair ----------------
	logic          o_v_q, o_ph_q;
	logic [DV-1:0] o_d1_q, o_d2_q;

	assign o_free     = !o_v_q || (o_ph_q && !dev_stall);
	assign adv        = o_free || !xv_s3;
	assign pair_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			o_ph_q <= 1'b0;
		end else if (o_free) begin
			o_v_q  <= xv_s3;
			o_ph_q <= 1'b0;
		end else if (!dev_stall) begin
			o_ph_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (o_free && xv_s3) begin
			o_d1_q <= fd1_s3;
			o_d2_q <= fd2_s3;
		end
	end

	assign dev_valid   = o_v_q;
	assign dev.deviate = o_ph_q ? o_d2_q : o_d1_q;
	assign dev.last    = o_ph_q;

	`ASSERT_NEXT(a_second_follows, o_v_q && !o_ph_q && !dev_stall, o_v_q && o_ph_q, "second deviate missing")
	`ASSERT_ALWAYS(a_phase_valid, !o_ph_q || o_v_q, "second phase without a pending pair")
	`ASSERT_ALWAYS(a_stall_cause, !pair_stall || (xv_s3 && o_v_q), "input stalled with room in the pipeline")
	`ASSERT_NEXT(a_hold_pair, o_v_q && dev_stall, o_v_q && $stable(o_d1_q) && $stable(o_d2_q), "held pair changed")

endmodule
